>>> rtl/core/ptpt_pkg.sv
// Shared types, constants and widths for the pan/tilt PID tracker.
package ptpt_pkg;

  localparam int COORD_BITS_DEF = 10;

  localparam int GAIN_W  = 24;
  localparam int FRAC_W  = 24;
  localparam int TGT_W   = 10;
  localparam int LIM_W   = 7;
  localparam int DT_W    = 20;
  localparam int ANG_W   = 8;
  localparam int INT_W   = 48;
  localparam int SUM_W   = 64;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_AW = 48;
  localparam int MUL_BW = 24;
  localparam int DIV_NW = MUL_AW + MUL_BW;
  localparam int DIV_DW = 20;

  localparam int ONE_MILLION = 1000000;
  localparam int DEADBAND    = 2;
  localparam int PAN_MAX     = 180;
  localparam int TILT_MAX    = 170;
  localparam int PAN_RESET   = 90;
  localparam int TILT_RESET  = 30;

  localparam logic [GAIN_W-1:0] PAN_KP_RESET  = 24'd100663;
  localparam logic [GAIN_W-1:0] PAN_KI_RESET  = 24'd10066;
  localparam logic [GAIN_W-1:0] TILT_KP_RESET = 24'd134218;
  localparam logic [GAIN_W-1:0] TILT_KI_RESET = 24'd10066;
  localparam logic [GAIN_W-1:0] KD_RESET      = 24'd33554;
  localparam logic [TGT_W-1:0]  TGT_X_RESET   = 10'd150;
  localparam logic [TGT_W-1:0]  TGT_Y_RESET   = 10'd120;
  localparam logic [LIM_W-1:0]  LIMIT_RESET   = 7'd45;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAN_KP   = 3'd0,
    CFG_PAN_KI   = 3'd1,
    CFG_TILT_KP  = 3'd2,
    CFG_TILT_KI  = 3'd3,
    CFG_KD       = 3'd4,
    CFG_TARGET_X = 3'd5,
    CFG_TARGET_Y = 3'd6,
    CFG_LIMIT    = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_M_EDT,
    ST_M_P,
    ST_M_I,
    ST_D_I,
    ST_M_D1,
    ST_M_D2,
    ST_D_D,
    ST_CLAMP,
    ST_ROUND,
    ST_NEXT,
    ST_DONE
  } state_e;

endpackage

>>> rtl/core/pan_tilt_pid_tracker.sv
// Top level of the pan/tilt PID tracker: sequencer, axis state and output register.
//
//   channel  direction  handshake                     payload
//   in       sink       in_valid_i / in_stall_o       face_valid_i nose_x_i nose_y_i dt_us_i
//   out      source     out_valid_o / out_stall_i     pan_deg_o tilt_deg_o pan/tilt_active_o
//   cfg      sink       cfg_valid_i / cfg_ready_o     cfg_index_i cfg_data_i
//
// The time from one accepted item to the next is longest when both axes are outside the
// deadband and shortest when neither is. It is set by the bit-serial multiplier (five
// products per axis) and the restoring divider (two divisions per axis), plus the setup,
// clamp, round and step states; no new item is taken until the result is loaded.
// Reset returns gains, targets, limit, PID state and angles to their defaults.
// A stalled result is held in the output register while the next item is worked on.
module pan_tilt_pid_tracker
  import ptpt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  face_valid_i,
  input  logic [COORD_BITS-1:0] nose_x_i,
  input  logic [COORD_BITS-1:0] nose_y_i,
  input  logic [DT_W-1:0]       dt_us_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ANG_W-1:0]      pan_deg_o,
  output logic [ANG_W-1:0]      tilt_deg_o,
  output logic                  pan_active_o,
  output logic                  tilt_active_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [GAIN_W-1:0]     cfg_data_i
);

  localparam int EW  = COORD_BITS + 1;
  localparam int DEW = COORD_BITS + 2;
  localparam int PW  = MUL_AW + MUL_BW;

  localparam logic signed [EW-1:0]    DB_P = EW'(DEADBAND);
  localparam logic signed [EW-1:0]    DB_N = -DB_P;
  localparam logic signed [INT_W:0]   IMAX = {2'b00, {(INT_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]        HALF = SUM_W'(1) << (FRAC_W - 1);
  localparam logic signed [ANG_W+1:0] PAN_TOP  = (ANG_W+2)'(PAN_MAX);
  localparam logic signed [ANG_W+1:0] TILT_TOP = (ANG_W+2)'(TILT_MAX);

  // Configuration registers.
  logic [GAIN_W-1:0] pan_kp_q, pan_ki_q, tilt_kp_q, tilt_ki_q, kd_q;
  logic [TGT_W-1:0]  tgt_x_q, tgt_y_q;
  logic [LIM_W-1:0]  lim_q;

  // Control and axis state.
  state_e                  state_q, state_d;
  logic                    axis_q, go_q;
  logic signed [INT_W-1:0] integ_q [2];
  logic signed [EW-1:0]    last_q [2];
  logic [ANG_W-1:0]        pan_pos_q, tilt_pos_q;
  logic [1:0]              act_q;
  logic                    out_valid_q;

  // Item payload and working values.
  logic                    face_q;
  logic [COORD_BITS-1:0]   nx_q, ny_q;
  logic [DT_W-1:0]         dt_q;
  logic [EW-1:0]           emag_q;
  logic                    eneg_q;
  logic [DEW-1:0]          dmag_q;
  logic                    dneg_q;
  logic signed [SUM_W-1:0] s_q;
  logic [ANG_W-1:0]        out_pan_q, out_tilt_q;
  logic                    out_pact_q, out_tact_q;

  // Serial units.
  logic              mul_start, mul_done, div_start, div_done;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PW-1:0]     mul_p;
  logic [DIV_NW-1:0] div_n, div_q;
  logic [DIV_DW-1:0] div_d;

  ptpt_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  ptpt_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .n_i(div_n), .d_i(div_d),
    .done_o(div_done), .q_o(div_q)
  );

  // Error of the current axis.
  logic [TGT_W+COORD_BITS-1:0] tgt_ext;
  logic [COORD_BITS-1:0]       tgt_c, nose_c;
  logic signed [EW-1:0]        e_c;
  logic signed [DEW-1:0]       de_c;
  logic                        active_c;

  assign tgt_ext  = {{COORD_BITS{1'b0}}, (axis_q ? tgt_y_q : tgt_x_q)};
  assign tgt_c    = tgt_ext[COORD_BITS-1:0];
  assign nose_c   = axis_q ? ny_q : nx_q;
  assign e_c      = $signed({1'b0, tgt_c}) - $signed({1'b0, nose_c});
  assign de_c     = $signed({e_c[EW-1], e_c}) - $signed({last_q[axis_q][EW-1], last_q[axis_q]});
  assign active_c = face_q && ((e_c > DB_P) || (e_c < DB_N));

  // Integral update after the error times dt product.
  logic signed [INT_W:0]   edt_s, isum;
  logic signed [INT_W-1:0] isat;
  logic signed [INT_W-1:0] integ_c;
  logic [MUL_AW-1:0]       imag_c;

  assign edt_s = eneg_q ? -$signed({1'b0, mul_p[INT_W-1:0]}) : $signed({1'b0, mul_p[INT_W-1:0]});
  assign isum  = $signed({integ_q[axis_q][INT_W-1], integ_q[axis_q]}) + edt_s;
  always_comb begin
    priority if (isum > IMAX) begin
      isat = IMAX[INT_W-1:0];
    end else if (isum < -IMAX) begin
      isat = INT_W'(-IMAX);
    end else begin
      isat = isum[INT_W-1:0];
    end
  end
  assign integ_c = integ_q[axis_q];
  assign imag_c  = MUL_AW'(integ_c[INT_W-1] ? -integ_c : integ_c);

  // Signed terms from unit results.
  logic signed [SUM_W-1:0] pmag_s, qmag_s, lim_s;
  assign pmag_s = $signed({1'b0, mul_p[SUM_W-2:0]});
  assign qmag_s = $signed({1'b0, div_q[SUM_W-2:0]});
  assign lim_s  = $signed(SUM_W'({lim_q, {FRAC_W{1'b0}}}));

  // Rounding and angle update.
  logic [SUM_W-1:0]        smag, srnd;
  logic [LIM_W-1:0]        rdeg;
  logic signed [ANG_W+1:0] delta, npos, nsat;
  logic [ANG_W-1:0]        cur_pos;
  logic                    sub_c;

  assign smag    = s_q[SUM_W-1] ? SUM_W'(-s_q) : SUM_W'(s_q);
  assign srnd    = smag + HALF;
  assign rdeg    = srnd[FRAC_W+LIM_W-1:FRAC_W];
  assign delta   = $signed({3'b000, rdeg});
  assign cur_pos = axis_q ? tilt_pos_q : pan_pos_q;
  // Tilt moves against the controller output.
  assign sub_c   = s_q[SUM_W-1] ^ axis_q;
  assign npos    = sub_c ? $signed({2'b00, cur_pos}) - delta : $signed({2'b00, cur_pos}) + delta;
  always_comb begin
    priority if (npos < 0) begin
      nsat = '0;
    end else if (axis_q && (npos > TILT_TOP)) begin
      nsat = TILT_TOP;
    end else if (!axis_q && (npos > PAN_TOP)) begin
      nsat = PAN_TOP;
    end else begin
      nsat = npos;
    end
  end

  logic op_done;
  logic out_load;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    unique case (state_q)
      ST_D_I, ST_D_D: op_done = div_done;
      default:        op_done = mul_done;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SETUP;
      ST_SETUP: state_d = active_c ? ST_M_EDT : ST_NEXT;
      ST_M_EDT: if (op_done) state_d = ST_M_P;
      ST_M_P:   if (op_done) state_d = ST_M_I;
      ST_M_I:   if (op_done) state_d = ST_D_I;
      ST_D_I:   if (op_done) state_d = ST_M_D1;
      ST_M_D1:  if (op_done) state_d = ST_M_D2;
      ST_M_D2:  if (op_done) state_d = ST_D_D;
      ST_D_D:   if (op_done) state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_ROUND;
      ST_ROUND: state_d = ST_NEXT;
      ST_NEXT:  state_d = axis_q ? ST_DONE : ST_SETUP;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Unit starts and operands.
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = MUL_AW'(dt_q);
    mul_b     = MUL_BW'(emag_q);
    div_n     = mul_p;
    div_d     = DIV_DW'(ONE_MILLION);
    unique case (state_q)
      ST_M_EDT: begin
        mul_start = !go_q;
      end
      ST_M_P: begin
        mul_start = !go_q;
        mul_a     = MUL_AW'(axis_q ? tilt_kp_q : pan_kp_q);
      end
      ST_M_I: begin
        mul_start = !go_q;
        mul_a     = imag_c;
        mul_b     = axis_q ? tilt_ki_q : pan_ki_q;
      end
      ST_D_I: begin
        div_start = !go_q;
      end
      ST_M_D1: begin
        mul_start = !go_q;
        mul_a     = MUL_AW'(kd_q);
        mul_b     = MUL_BW'(dmag_q);
      end
      ST_M_D2: begin
        mul_start = !go_q;
        mul_a     = mul_p[MUL_AW-1:0];
        mul_b     = MUL_BW'(ONE_MILLION);
      end
      ST_D_D: begin
        div_start = !go_q;
        div_d     = dt_q;
      end
      default: begin
      end
    endcase
  end

  // Control, configuration and axis state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      go_q        <= 1'b0;
      pan_kp_q    <= PAN_KP_RESET;
      pan_ki_q    <= PAN_KI_RESET;
      tilt_kp_q   <= TILT_KP_RESET;
      tilt_ki_q   <= TILT_KI_RESET;
      kd_q        <= KD_RESET;
      tgt_x_q     <= TGT_X_RESET;
      tgt_y_q     <= TGT_Y_RESET;
      lim_q       <= LIMIT_RESET;
      integ_q[0]  <= '0;
      integ_q[1]  <= '0;
      last_q[0]   <= '0;
      last_q[1]   <= '0;
      pan_pos_q   <= ANG_W'(PAN_RESET);
      tilt_pos_q  <= ANG_W'(TILT_RESET);
      act_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_start || div_start) begin
        go_q <= 1'b1;
      end else if (op_done) begin
        go_q <= 1'b0;
      end

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_PAN_KP:   pan_kp_q  <= cfg_data_i;
          CFG_PAN_KI:   pan_ki_q  <= cfg_data_i;
          CFG_TILT_KP:  tilt_kp_q <= cfg_data_i;
          CFG_TILT_KI:  tilt_ki_q <= cfg_data_i;
          CFG_KD:       kd_q      <= cfg_data_i;
          CFG_TARGET_X: tgt_x_q   <= cfg_data_i[TGT_W-1:0];
          CFG_TARGET_Y: tgt_y_q   <= cfg_data_i[TGT_W-1:0];
          CFG_LIMIT:    lim_q     <= cfg_data_i[LIM_W-1:0];
          default: begin
          end
        endcase
      end

      if (state_q == ST_IDLE) begin
        axis_q <= 1'b0;
      end
      if (state_q == ST_NEXT) begin
        axis_q <= 1'b1;
      end

      if (state_q == ST_SETUP) begin
        act_q[axis_q] <= active_c;
        if (active_c) begin
          last_q[axis_q] <= e_c;
        end else begin
          integ_q[axis_q] <= '0;
          last_q[axis_q]  <= '0;
        end
      end
      if ((state_q == ST_M_EDT) && mul_done) begin
        integ_q[axis_q] <= isat;
      end
      if (state_q == ST_ROUND) begin
        if (axis_q) begin
          tilt_pos_q <= nsat[ANG_W-1:0];
        end else begin
          pan_pos_q <= nsat[ANG_W-1:0];
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      face_q <= face_valid_i;
      nx_q   <= nose_x_i;
      ny_q   <= nose_y_i;
      dt_q   <= (dt_us_i == '0) ? DT_W'(1) : dt_us_i;
    end
    if (state_q == ST_SETUP) begin
      eneg_q <= e_c[EW-1];
      emag_q <= EW'(e_c[EW-1] ? -e_c : e_c);
      dneg_q <= de_c[DEW-1];
      dmag_q <= DEW'(de_c[DEW-1] ? -de_c : de_c);
    end
    if ((state_q == ST_M_P) && mul_done) begin
      s_q <= eneg_q ? -pmag_s : pmag_s;
    end
    if ((state_q == ST_D_I) && div_done) begin
      s_q <= integ_c[INT_W-1] ? s_q - qmag_s : s_q + qmag_s;
    end
    if ((state_q == ST_D_D) && div_done) begin
      s_q <= dneg_q ? s_q - qmag_s : s_q + qmag_s;
    end
    if (state_q == ST_CLAMP) begin
      priority if (s_q > lim_s) begin
        s_q <= lim_s;
      end else if (s_q < -lim_s) begin
        s_q <= -lim_s;
      end else begin
        s_q <= s_q;
      end
    end
    if (out_load) begin
      out_pan_q  <= pan_pos_q;
      out_tilt_q <= tilt_pos_q;
      out_pact_q <= act_q[0];
      out_tact_q <= act_q[1];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pan_deg_o     = out_pan_q;
  assign tilt_deg_o    = out_tilt_q;
  assign pan_active_o  = out_pact_q;
  assign tilt_active_o = out_tact_q;

endmodule

>>> rtl/core/ptpt_mul.sv
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
module ptpt_mul
  import ptpt_pkg::*;
#(
  parameter int AW = MUL_AW,
  parameter int BW = MUL_BW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] p_o
);

  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_q, a_q;
  logic [BW-1:0]    b_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= (AW+BW)'(a_i);
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[AW+BW-2:0], 1'b0};
      b_q <= {1'b0, b_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

>>> rtl/core/ptpt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ptpt_div
  import ptpt_pkg::*;
#(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic          done_o,
  output logic [NW-1:0] q_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] work_q;
  logic [DW-1:0] rem_q, d_q;
  logic [DW:0]   sh;
  logic          fits;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  assign sh   = {rem_q, work_q[NW-1]};
  assign fits = sh >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= n_i;
      rem_q  <= '0;
      d_q    <= d_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so the trial value needs one extra bit.
      if (fits) begin
        rem_q <= DW'(sh - {1'b0, d_q});
      end else begin
        rem_q <= sh[DW-1:0];
      end
      work_q <= {work_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign q_o    = work_q;

endmodule

>>> verif/pan_tilt_pid_tracker_tb.sv
// Self-checking testbench for the pan/tilt PID tracker with its own PID predictor.
module pan_tilt_pid_tracker_tb;
  import ptpt_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam longint MILLION = 1000000;
  localparam longint INTEG_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic            face;
    logic [CB-1:0]   nx;
    logic [CB-1:0]   ny;
    logic [DT_W-1:0] dt;
  } sample_t;

  typedef struct packed {
    logic [ANG_W-1:0] pan;
    logic [ANG_W-1:0] tilt;
    logic             pan_act;
    logic             tilt_act;
  } angles_t;

  logic clk, rst_ni;
  logic in_valid, in_stall, face_valid;
  logic [CB-1:0] nose_x, nose_y;
  logic [DT_W-1:0] dt_us;
  logic out_valid, out_stall;
  logic [ANG_W-1:0] pan_deg, tilt_deg;
  logic pan_active, tilt_active;
  logic cfg_valid, cfg_ready;
  cfg_idx_e cfg_index;
  logic [GAIN_W-1:0] cfg_data;

  pan_tilt_pid_tracker dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .face_valid_i(face_valid), .nose_x_i(nose_x), .nose_y_i(nose_y), .dt_us_i(dt_us),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pan_deg_o(pan_deg), .tilt_deg_o(tilt_deg),
    .pan_active_o(pan_active), .tilt_active_o(tilt_active),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Predictor copy of the registers and the axis state (index 0 pan, 1 tilt).
  longint gain_kp[2], gain_ki[2], gain_kd, tgt_x, tgt_y, out_lim;
  longint integ[2], last_err[2];
  int pan_pos, tilt_pos;

  sample_t samples_q[$];
  angles_t angles_q[$];
  int n_sent, n_checked, n_cfg, n_mismatch;
  bit quiet_tail, long_hold_req, long_hold_done;
  // Set at the rising edge when the current input item was taken.
  int send_gap;
  bit took;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pid_step(int ax, longint e, longint dt);
    longint acc, de, p, mag, im, it, d, s, lim, sm, r;
    acc = integ[ax] + e * dt;
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    if (acc < -INTEG_MAX) acc = -INTEG_MAX;
    integ[ax] = acc;
    de = e - last_err[ax];
    last_err[ax] = e;
    p = gain_kp[ax] * e;
    mag = (acc < 0) ? -acc : acc;
    im = gain_ki[ax] * (mag / MILLION) + (gain_ki[ax] * (mag % MILLION)) / MILLION;
    it = (acc < 0) ? -im : im;
    d = (gain_kd * de * MILLION) / dt;
    s = p + it + d;
    lim = out_lim <<< 24;
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    sm = (s < 0) ? -s : s;
    r = (sm + (64'sd1 <<< 23)) >>> 24;
    return (s < 0) ? -int'(r) : int'(r);
  endfunction

  function automatic angles_t track_sample(sample_t smp);
    angles_t res;
    longint dt, ex, ey;
    dt = (smp.dt == 0) ? 1 : longint'(smp.dt);
    res.pan_act = 1'b0;
    res.tilt_act = 1'b0;
    if (!smp.face) begin
      integ = '{0, 0};
      last_err = '{0, 0};
    end else begin
      ex = tgt_x - longint'(smp.nx);
      ey = tgt_y - longint'(smp.ny);
      if (ex > DEADBAND || ex < -DEADBAND) begin
        res.pan_act = 1'b1;
        pan_pos += pid_step(0, ex, dt);
        if (pan_pos < 0) pan_pos = 0;
        if (pan_pos > PAN_MAX) pan_pos = PAN_MAX;
      end else begin
        integ[0] = 0;
        last_err[0] = 0;
      end
      if (ey > DEADBAND || ey < -DEADBAND) begin
        res.tilt_act = 1'b1;
        tilt_pos -= pid_step(1, ey, dt);
        if (tilt_pos < 0) tilt_pos = 0;
        if (tilt_pos > TILT_MAX) tilt_pos = TILT_MAX;
      end else begin
        integ[1] = 0;
        last_err[1] = 0;
      end
    end
    res.pan = pan_pos[ANG_W-1:0];
    res.tilt = tilt_pos[ANG_W-1:0];
    return res;
  endfunction

  function automatic void apply_cfg(cfg_idx_e idx, logic [GAIN_W-1:0] v);
    case (idx)
      CFG_PAN_KP:   gain_kp[0] = v;
      CFG_PAN_KI:   gain_ki[0] = v;
      CFG_TILT_KP:  gain_kp[1] = v;
      CFG_TILT_KI:  gain_ki[1] = v;
      CFG_KD:       gain_kd = v;
      CFG_TARGET_X: tgt_x = v[TGT_W-1:0];
      CFG_TARGET_Y: tgt_y = v[TGT_W-1:0];
      CFG_LIMIT:    out_lim = v[LIM_W-1:0];
      default: ;
    endcase
  endfunction

  // Rising edge: track accepted items and config writes, check results.
  always @(posedge clk) begin
    angles_t got, want;
    sample_t smp;
    took = rst_ni && in_valid && !in_stall;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        apply_cfg(cfg_index, cfg_data);
        n_cfg++;
      end
      if (in_valid && !in_stall) begin
        smp = '{face_valid, nose_x, nose_y, dt_us};
        angles_q.push_back(track_sample(smp));
        n_sent++;
      end
      if (out_valid && !out_stall) begin
        got = '{pan_deg, tilt_deg, pan_active, tilt_active};
        if (angles_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result pan %0d tilt %0d", pan_deg, tilt_deg);
        end else begin
          want = angles_q.pop_front();
          n_checked++;
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display({"result %0d: expected pan %0d tilt %0d act %b%b, ",
                        "got pan %0d tilt %0d act %b%b"},
                       n_checked, want.pan, want.tilt, want.pan_act, want.tilt_act,
                       got.pan, got.tilt, got.pan_act, got.tilt_act);
          end
        end
      end
    end
  end

  // Sender: one item per handshake, with random gaps between items.
  always @(negedge clk) begin
    sample_t smp;
    if (rst_ni && (!in_valid || took)) begin
      if (took && !quiet_tail && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 16);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (samples_q.size() > 0) begin
        smp = samples_q.pop_front();
        face_valid <= smp.face;
        nose_x <= smp.nx;
        nose_y <= smp.ny;
        dt_us <= smp.dt;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off on request.
  int stall_left;
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      stall_left = 3000;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  int cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("pan_tilt_pid_tracker test failed");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (samples_q.size() != 0 || in_valid || angles_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [GAIN_W-1:0] v);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add(int f, int x, int y, int dt);
    samples_q.push_back('{f != 0, x[CB-1:0], y[CB-1:0], dt[DT_W-1:0]});
  endtask

  task automatic add_random();
    int x, y, dt;
    case ($urandom_range(0, 9))
      0, 1:    begin x = $urandom_range(0, 1023); y = $urandom_range(0, 1023); end
      2:       begin
        x = int'(tgt_x) + ($urandom_range(0, 1) ? 3 : -3);
        y = int'(tgt_y) + $urandom_range(0, 6) - 3;
      end
      default: begin
        x = int'(tgt_x) + $urandom_range(0, 80) - 40;
        y = int'(tgt_y) + $urandom_range(0, 80) - 40;
      end
    endcase
    case ($urandom_range(0, 9))
      0:       dt = 0;
      1:       dt = $urandom_range(0, 'hFFFFF);
      default: dt = $urandom_range(10000, 40000);
    endcase
    add($urandom_range(0, 15) != 0, x, y, dt);
  endtask

  task automatic run_random(int n);
    repeat (n) add_random();
    wait_idle();
  endtask

  task automatic cfg_all(int kp0, int ki0, int kp1, int ki1, int kd, int tx, int ty, int lim);
    cfg_write(CFG_PAN_KP, kp0[GAIN_W-1:0]);
    cfg_write(CFG_PAN_KI, ki0[GAIN_W-1:0]);
    cfg_write(CFG_TILT_KP, kp1[GAIN_W-1:0]);
    cfg_write(CFG_TILT_KI, ki1[GAIN_W-1:0]);
    cfg_write(CFG_KD, kd[GAIN_W-1:0]);
    cfg_write(CFG_TARGET_X, tx[GAIN_W-1:0]);
    cfg_write(CFG_TARGET_Y, ty[GAIN_W-1:0]);
    cfg_write(CFG_LIMIT, lim[GAIN_W-1:0]);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0; face_valid = 1'b0; nose_x = '0; nose_y = '0; dt_us = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_PAN_KP; cfg_data = '0;
    gain_kp = '{PAN_KP_RESET, TILT_KP_RESET};
    gain_ki = '{PAN_KI_RESET, TILT_KI_RESET};
    gain_kd = KD_RESET; tgt_x = TGT_X_RESET; tgt_y = TGT_Y_RESET; out_lim = LIMIT_RESET;
    integ = '{0, 0}; last_err = '{0, 0};
    pan_pos = PAN_RESET; tilt_pos = TILT_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Reset defaults: no face, deadband edges, coordinate and time extremes.
    add(0, 400, 400, 20000);
    add(1, 150, 120, 20000);
    add(1, 152, 118, 20000);
    add(1, 148, 122, 20000);
    add(1, 153, 117, 20000);
    add(1, 147, 123, 20000);
    add(1, 0, 0, 0);
    add(1, 0, 0, 0);
    add(1, 1023, 1023, 'hFFFFF);
    add(1, 1023, 1023, 'hFFFFF);
    add(1, 100, 200, 1);
    add(1, 200, 50, 33000);
    add(1, 200, 50, 33000);
    add(0, 1023, 0, 0);
    add(1, 151, 10, 15000);
    add(1, 10, 121, 15000);
    wait_idle();

    // Largest gains and limit, targets at the low corner.
    cfg_all('hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 0, 0, 127);
    add(1, 1023, 1023, 'hFFFFF);
    add(1, 1023, 1023, 0);
    add(1, 0, 0, 1);
    add(1, 3, 2, 500);
    run_random(40);

    // Zero gains and zero limit, targets at the high corner; data wider than fields.
    cfg_all(0, 0, 0, 0, 0, 'hFFFC00 | 1023, 'hABC000 | 1023, 'hFFFF80);
    add(1, 0, 0, 'hFFFFF);
    run_random(20);

    // Moderate random settings; one phase with a long output hold-off.
    for (int ph = 0; ph < 5; ph++) begin
      cfg_all($urandom_range(0, 400000), $urandom_range(0, 60000), $urandom_range(0, 400000),
              $urandom_range(0, 60000), $urandom_range(0, 200000), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(1, 127));
      if (ph == 2) long_hold_req = 1'b1;
      run_random(60);
    end

    // Back to the reset values with no idling on either side.
    cfg_all(int'(PAN_KP_RESET), int'(PAN_KI_RESET), int'(TILT_KP_RESET), int'(TILT_KI_RESET),
            int'(KD_RESET), int'(TGT_X_RESET), int'(TGT_Y_RESET), int'(LIMIT_RESET));
    quiet_tail = 1'b1;
    run_random(40);

    $display("Covered %0d samples and %0d checked results over %0d register writes,",
             n_sent, n_checked, n_cfg);
    $display("including gain, target and limit extremes and a long output hold-off.");
    if (n_mismatch == 0 && angles_q.size() == 0) begin
      $display("pan_tilt_pid_tracker test passed");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("pan_tilt_pid_tracker test failed");
    end
    $finish;
  end

endmodule
